// File: hw/rtl/klbs_pkg.sv
// Shared types, constants and table functions for the keyboard LED blink sequencer.
`default_nettype none

package klbs_pkg;

  // Timer and configuration widths
  localparam int TIMER_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int STEP_W      = 3;

  localparam logic [31:0] TIMER_MAX32 = 32'hFFFF_FFFF >> (32 - TIMER_W);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_WAIT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_QUIT_CODE  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_CODE = CFG_INDEX_W'(3);

  // Register reset values
  localparam logic [15:0] ACK_WAIT_RESET   = 16'd1800;
  localparam logic [15:0] SETTLE_RESET     = 16'd50;
  localparam logic [7:0]  QUIT_CODE_RESET  = 8'h01;
  localparam logic [7:0]  BLINK_CODE_RESET = 8'h26;

  // Opcodes and protocol bytes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [7:0] CMD_SET_LEDS = 8'hED;
  localparam logic [7:0] RSP_ACK      = 8'hFA;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(5);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEND_CMD  = 3'd1,
    PH_WAIT_ACK  = 3'd2,
    PH_SEND_MASK = 3'd3,
    PH_SETTLE    = 3'd4,
    PH_HOLD      = 3'd5
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       ctrl_busy;
  } klbs_in_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        send_byte;
    logic              quit_flag;
    logic              blink_active;
    logic [STEP_W-1:0] pattern_step;
    logic              ack_timeout;
  } klbs_out_t;

  // Classified beat handed from front to back
  typedef struct packed {
    logic is_byte;
    logic is_quit;
    logic is_blink;
    logic is_ack;
    logic busy;
  } klbs_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] ack_wait_ticks;
    logic [CFG_DATA_W-1:0] settle_ticks;
  } klbs_cfg_t;

  function automatic logic [TIMER_W-1:0] timer_load(input logic [15:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > TIMER_MAX32) begin
      return TIMER_MAX32[TIMER_W-1:0];
    end
    return wide[TIMER_W-1:0];
  endfunction

  function automatic logic [7:0] step_mask(input logic [STEP_W-1:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0:    m = 8'h02;
      3'd1:    m = 8'h04;
      3'd2:    m = 8'h06;
      3'd3:    m = 8'h00;
      3'd4:    m = 8'h06;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] step_hold(input logic [STEP_W-1:0] idx);
    logic [15:0] h;
    unique case (idx)
      3'd0:    h = 16'd150;
      3'd1:    h = 16'd150;
      3'd2:    h = 16'd200;
      3'd3:    h = 16'd50;
      3'd4:    h = 16'd100;
      default: h = 16'd0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/klbs_front.sv
// Front end: configuration registers and classification of incoming beats.
`default_nettype none

module klbs_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [klbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [klbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  klbs_pkg::klbs_in_t               in_data,
  output klbs_pkg::klbs_item_t             item,
  output klbs_pkg::klbs_cfg_t              cfg
);
  import klbs_pkg::*;

  logic [15:0] ack_wait_ticks;
  logic [15:0] settle_ticks;
  logic [7:0]  quit_scancode;
  logic [7:0]  blink_scancode;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_ticks <= ACK_WAIT_RESET;
      settle_ticks   <= SETTLE_RESET;
      quit_scancode  <= QUIT_CODE_RESET;
      blink_scancode <= BLINK_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_WAIT:   ack_wait_ticks <= cfg_wdata[15:0];
        REG_SETTLE:     settle_ticks   <= cfg_wdata[15:0];
        REG_QUIT_CODE:  quit_scancode  <= cfg_wdata[7:0];
        REG_BLINK_CODE: blink_scancode <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic is_byte;
  assign is_byte = (in_data.opcode == OP_BYTE);

  always_comb begin
    item.is_byte  = is_byte;
    item.is_quit  = is_byte && (in_data.rx_byte == quit_scancode);
    item.is_blink = is_byte && (in_data.rx_byte == blink_scancode);
    item.is_ack   = is_byte && (in_data.rx_byte == RSP_ACK);
    item.busy     = in_data.ctrl_busy;
  end

  assign cfg.ack_wait_ticks = ack_wait_ticks;
  assign cfg.settle_ticks   = settle_ticks;

endmodule

`default_nettype wire

// File: hw/rtl/klbs_queue.sv
// Short queue of classified beats between front and back.
`default_nettype none

module klbs_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  klbs_pkg::klbs_item_t  push_item,
  output logic                  full,
  input  wire                   pop,
  output logic                  nonempty,
  output klbs_pkg::klbs_item_t  head
);
  import klbs_pkg::*;

  klbs_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  logic do_push;
  logic do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/klbs_back.sv
// Back end: LED exchange sequencer and registered result beat.
`default_nettype none

module klbs_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  input  klbs_pkg::klbs_item_t  item,
  output logic                  item_ready,
  input  klbs_pkg::klbs_cfg_t   cfg,
  output logic                  out_valid,
  input  wire                   out_ready,
  output klbs_pkg::klbs_out_t   out_data
);
  import klbs_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic [STEP_W-1:0]    step_index;
  logic [STEP_W-1:0]    step_index_next;
  logic [TIMER_W-1:0]   wait_timer;
  logic [TIMER_W-1:0]   wait_timer_next;
  logic                 quit_latched;
  logic                 quit_latched_next;
  logic                 blink_running;
  logic                 blink_running_next;
  klbs_out_t            result;
  logic                 take;

  // Take a beat whenever the result register is free or being drained
  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      step_index    <= '0;
      wait_timer    <= '0;
      quit_latched  <= 1'b0;
      blink_running <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        step_index    <= step_index_next;
        wait_timer    <= wait_timer_next;
        quit_latched  <= quit_latched_next;
        blink_running <= blink_running_next;
      end
      if (item_ready) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

  always_comb begin
    logic [STEP_W-1:0] idx;
    logic              expired;
    logic              send;
    logic [7:0]        sbyte;
    logic              timeout;

    phase_next         = phase;
    step_index_next    = step_index;
    wait_timer_next    = wait_timer;
    quit_latched_next  = quit_latched;
    blink_running_next = blink_running;
    send    = 1'b0;
    sbyte   = 8'h00;
    timeout = 1'b0;
    idx     = (step_index > LAST_STEP) ? LAST_STEP : step_index;
    expired = (wait_timer <= TIMER_W'(1));

    if (item.is_byte) begin
      if (item.is_quit) begin
        quit_latched_next = 1'b1;
      end
      if (item.is_blink && phase == PH_IDLE && !blink_running && !quit_latched_next) begin
        blink_running_next = 1'b1;
        step_index_next    = '0;
        idx                = '0;
        phase_next         = PH_SEND_CMD;
      end else if (phase == PH_WAIT_ACK && item.is_ack) begin
        phase_next = PH_SEND_MASK;
      end
    end else if (phase == PH_WAIT_ACK || phase == PH_SETTLE || phase == PH_HOLD) begin
      priority if (!expired) begin
        wait_timer_next = wait_timer - TIMER_W'(1);
      end else if (phase == PH_WAIT_ACK) begin
        timeout         = 1'b1;
        phase_next      = PH_SETTLE;
        wait_timer_next = timer_load(cfg.settle_ticks);
      end else if (phase == PH_SETTLE) begin
        phase_next      = PH_HOLD;
        wait_timer_next = timer_load(step_hold(idx));
      end else if (idx >= LAST_STEP) begin
        phase_next         = PH_IDLE;
        step_index_next    = '0;
        idx                = '0;
        wait_timer_next    = '0;
        blink_running_next = 1'b0;
      end else begin
        step_index_next = idx + STEP_W'(1);
        idx             = idx + STEP_W'(1);
        phase_next      = PH_SEND_CMD;
      end
    end

    // Try a send last so a phase entered by this beat can send at once
    if (!item.busy) begin
      if (phase_next == PH_SEND_CMD) begin
        send            = 1'b1;
        sbyte           = CMD_SET_LEDS;
        phase_next      = PH_WAIT_ACK;
        wait_timer_next = timer_load(cfg.ack_wait_ticks);
      end else if (phase_next == PH_SEND_MASK) begin
        send            = 1'b1;
        sbyte           = step_mask(idx);
        phase_next      = PH_SETTLE;
        wait_timer_next = timer_load(cfg.settle_ticks);
      end
    end

    result.send_valid   = send;
    result.send_byte    = sbyte;
    result.quit_flag    = quit_latched_next;
    result.blink_active = blink_running_next;
    result.pattern_step = step_index_next;
    result.ack_timeout  = timeout;
  end

endmodule

`default_nettype wire

// File: hw/rtl/keyboard_led_blink_sequencer.sv
// Top level of the keyboard LED blink sequencer.
`default_nettype none

// Host side of the keyboard set-indicators exchange. Each input beat is a 1 ms
// tick (opcode 0) or a received byte (opcode 1) and yields exactly one result
// beat with the byte to send, if any, and the quit, running and step status.
// The front classifies beats against the configured scancodes and pushes them
// into a two-entry queue; the back runs the LED exchange state machine and
// holds the result in an output register. One beat is taken every clock while
// the queue is not full; the rate is set by the back's single state update per
// beat, and a result passes through a queue slot and then the output register.
// Configuration is a plain write port: index 0 ack wait, 1 settle time, 2 quit
// scancode, 3 blink scancode; other indexes are ignored.
module keyboard_led_blink_sequencer (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [klbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [klbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  klbs_pkg::klbs_in_t               in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output klbs_pkg::klbs_out_t              out_data
);
  import klbs_pkg::*;

  klbs_item_t front_item;
  klbs_item_t queue_head;
  klbs_cfg_t  cfg;
  logic       queue_full;
  logic       queue_nonempty;
  logic       back_ready;

  assign in_ready = !queue_full;

  klbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .item      (front_item),
    .cfg       (cfg)
  );

  klbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (back_ready),
    .nonempty  (queue_nonempty),
    .head      (queue_head)
  );

  klbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_nonempty),
    .item       (queue_head),
    .item_ready (back_ready),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Idle beats send nothing
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.send_valid |-> out_data.send_byte == 8'h00)
    else $error("send_byte nonzero without a send");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pattern_step <= LAST_STEP)
    else $error("pattern_step beyond last step");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.blink_active |-> out_data.pattern_step == '0)
    else $error("pattern_step nonzero while not running");

  a_timeout_no_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ack_timeout |-> !out_data.send_valid && out_data.blink_active)
    else $error("ack timeout with a send or outside a pattern");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the keyboard LED blink sequencer: table-driven and random beats.
`timescale 1ns / 1ps

module tb_top;
  import klbs_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(7);

  typedef struct packed {
    klbs_in_t  stim;
    logic      typed;
    klbs_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  klbs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  klbs_out_t out_data;

  // shadow of the sequencer
  phase_t sh_phase = PH_IDLE;
  logic [STEP_W-1:0] sh_step = '0;
  logic [TIMER_W-1:0] sh_timer = '0;
  logic sh_quit = 1'b0;
  logic sh_running = 1'b0;
  logic [15:0] cf_ack = ACK_WAIT_RESET;
  logic [15:0] cf_settle = SETTLE_RESET;
  logic [7:0] cf_quit = QUIT_CODE_RESET;
  logic [7:0] cf_blink = BLINK_CODE_RESET;

  logic [7:0] led_mask [6] = '{8'h02, 8'h04, 8'h06, 8'h00, 8'h06, 8'h00};
  logic [15:0] hold_ticks [6] = '{16'd150, 16'd150, 16'd200, 16'd50, 16'd100, 16'd0};

  klbs_out_t status_due_q [$];
  int err_cnt = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 49;
  int stall_asks = 0;
  int stall_seen = 0;
  int hold_left = 0;

  dir_row_t dir_rows [15] = '{
    '{'{OP_TICK, 8'h00, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0}},
    '{'{OP_BYTE, RSP_ACK, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0}},
    '{'{OP_BYTE, 8'hFF, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0}},
    '{'{OP_BYTE, 8'h00, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0}},
    '{'{OP_TICK, 8'hFF, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0}},
    '{'{OP_BYTE, BLINK_CODE_RESET, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 1'b0}},
    '{'{OP_TICK, 8'h00, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 1'b0}},
    '{'{OP_TICK, 8'h00, 1'b0}, 1'b1, '{1'b1, CMD_SET_LEDS, 1'b0, 1'b1, 3'd0, 1'b0}},
    '{'{OP_BYTE, BLINK_CODE_RESET, 1'b0}, 1'b0, '0},
    '{'{OP_BYTE, 8'h55, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 8'hAA, 1'b0}, 1'b0, '0},
    '{'{OP_BYTE, RSP_ACK, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 1'b0}},
    '{'{OP_TICK, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'h02, 1'b0, 1'b1, 3'd0, 1'b0}},
    '{'{OP_BYTE, RSP_ACK, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 8'hFF, 1'b1}, 1'b0, '0}
  };

  keyboard_led_blink_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string what);
    if (err_cnt < 40) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    err_cnt++;
  endtask

  // Advance the shadow by one beat; byte first, then tick, then send.
  function automatic klbs_out_t led_seq_step(input klbs_in_t it);
    klbs_out_t res;
    logic [STEP_W-1:0] idx;
    logic expired;
    res = '0;
    idx = (sh_step > LAST_STEP) ? LAST_STEP : sh_step;
    if (it.opcode == OP_BYTE) begin
      if (it.rx_byte == cf_quit) sh_quit = 1'b1;
      if (it.rx_byte == cf_blink && sh_phase == PH_IDLE && !sh_running && !sh_quit) begin
        sh_running = 1'b1;
        sh_step = '0;
        idx = '0;
        sh_phase = PH_SEND_CMD;
      end else if (sh_phase == PH_WAIT_ACK && it.rx_byte == RSP_ACK) begin
        sh_phase = PH_SEND_MASK;
      end
    end else if (sh_phase == PH_WAIT_ACK || sh_phase == PH_SETTLE || sh_phase == PH_HOLD) begin
      expired = (sh_timer <= 1);
      if (!expired) begin
        sh_timer = sh_timer - 1'b1;
      end else if (sh_phase == PH_WAIT_ACK) begin
        res.ack_timeout = 1'b1;
        sh_phase = PH_SETTLE;
        sh_timer = cf_settle;
      end else if (sh_phase == PH_SETTLE) begin
        sh_phase = PH_HOLD;
        sh_timer = hold_ticks[idx];
      end else if (idx >= LAST_STEP) begin
        sh_phase = PH_IDLE;
        sh_step = '0;
        idx = '0;
        sh_timer = '0;
        sh_running = 1'b0;
      end else begin
        sh_step = idx + 1'b1;
        idx = sh_step;
        sh_phase = PH_SEND_CMD;
      end
    end
    if (!it.ctrl_busy) begin
      if (sh_phase == PH_SEND_CMD) begin
        res.send_valid = 1'b1;
        res.send_byte = CMD_SET_LEDS;
        sh_phase = PH_WAIT_ACK;
        sh_timer = cf_ack;
      end else if (sh_phase == PH_SEND_MASK) begin
        res.send_valid = 1'b1;
        res.send_byte = led_mask[idx];
        sh_phase = PH_SETTLE;
        sh_timer = cf_settle;
      end
    end
    res.quit_flag = sh_quit;
    res.blink_active = sh_running;
    res.pattern_step = sh_step;
    return res;
  endfunction

  // Any byte but the quit code, so the quit latch stays clear until wanted.
  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cf_quit);
    return b;
  endfunction

  // Mostly well-formed exchanges: starts when idle, acks while waiting, ticks otherwise.
  function automatic klbs_in_t pick_item();
    klbs_in_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.opcode = OP_TICK;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.ctrl_busy = ($urandom_range(0, 99) < 20);
    unique case (sh_phase)
      PH_IDLE: begin
        if (roll < 40) begin
          it.opcode = OP_BYTE;
          it.rx_byte = cf_blink;
        end else if (roll < 55) begin
          it.opcode = OP_BYTE;
          it.rx_byte = stray_byte();
        end
      end
      PH_WAIT_ACK: begin
        if (roll < 30) begin
          it.opcode = OP_BYTE;
          it.rx_byte = RSP_ACK;
        end else if (roll < 40) begin
          it.opcode = OP_BYTE;
          it.rx_byte = stray_byte();
        end
      end
      default: begin
        if (roll < 6) begin
          it.opcode = OP_BYTE;
          it.rx_byte = stray_byte();
        end else if (roll < 8) begin
          it.opcode = OP_BYTE;
          it.rx_byte = cf_blink;
        end
      end
    endcase
    return it;
  endfunction

  task automatic put_item(input klbs_in_t it, input logic typed, input klbs_out_t want);
    klbs_out_t got;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = led_seq_step(it);
    status_due_q.push_back(typed ? want : got);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic tick_run(input int n);
    klbs_in_t it;
    for (int k = 0; k < n; k++) begin
      it.opcode = OP_TICK;
      it.rx_byte = 8'($urandom_range(0, 255));
      it.ctrl_busy = ($urandom_range(0, 99) < 20);
      put_item(it, 1'b0, '0);
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_item('{OP_BYTE, b, 1'b0}, 1'b0, '0);
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      // hold the output side off midway so the input backs up
      if (k == n / 2) stall_asks++;
      put_item(pick_item(), 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register plus one unused index; junk in the upper bits of byte codes.
  task automatic load_regs(input logic [15:0] ack, input logic [15:0] settle,
                           input logic [7:0] quit, input logic [7:0] blink);
    logic [CFG_INDEX_W-1:0] ids [5];
    logic [15:0] vals [5];
    ids = '{REG_ACK_WAIT, REG_SETTLE, REG_QUIT_CODE, REG_BLINK_CODE, REG_SPARE};
    vals = '{ack, settle, {8'hA5, quit}, {8'h5A, blink}, 16'($urandom)};
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= ids[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
      unique case (ids[k])
        REG_ACK_WAIT:   cf_ack = vals[k];
        REG_SETTLE:     cf_settle = vals[k];
        REG_QUIT_CODE:  cf_quit = vals[k][7:0];
        REG_BLINK_CODE: cf_blink = vals[k][7:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (stall_seen != stall_asks) begin
      stall_seen = stall_asks;
      hold_left = 60;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    klbs_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (status_due_q.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = status_due_q.pop_front();
        if (out_data.send_valid !== want.send_valid)
          note_mismatch($sformatf("send_valid %0h, want %0h",
                                  out_data.send_valid, want.send_valid));
        if (out_data.send_byte !== want.send_byte)
          note_mismatch($sformatf("send_byte %0h, want %0h",
                                  out_data.send_byte, want.send_byte));
        if (out_data.quit_flag !== want.quit_flag)
          note_mismatch($sformatf("quit_flag %0h, want %0h",
                                  out_data.quit_flag, want.quit_flag));
        if (out_data.blink_active !== want.blink_active)
          note_mismatch($sformatf("blink_active %0h, want %0h",
                                  out_data.blink_active, want.blink_active));
        if (out_data.pattern_step !== want.pattern_step)
          note_mismatch($sformatf("pattern_step %0h, want %0h",
                                  out_data.pattern_step, want.pattern_step));
        if (out_data.ack_timeout !== want.ack_timeout)
          note_mismatch($sformatf("ack_timeout %0h, want %0h",
                                  out_data.ack_timeout, want.ack_timeout));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) put_item(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);
    drain();

    load_regs(16'd5, 16'd2, 8'hFF, 8'h00);
    run_random(420);
    drain();

    send_idle_pct = 49;
    recv_idle_pct = 22;
    // blink code equal to the acknowledge byte
    load_regs(16'd1, 16'd0, 8'h00, RSP_ACK);
    run_random(420);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs(16'd12, 16'd3, 8'h80, 8'hFF);
    run_random(420);
    while (sh_running) tick_run(1);
    drain();

    // widest waits; quit arrives mid-pattern and must not stop it
    load_regs(16'hFFFF, 16'hFFFF, 8'h5A, 8'h26);
    put_byte(8'h26);
    tick_run(20);
    put_byte(RSP_ACK);
    tick_run(20);
    put_byte(8'h5A);
    tick_run(20);
    put_byte(8'h26);
    drain();

    // one code for both quit and blink
    load_regs(16'hFFFF, 16'hFFFF, 8'h99, 8'h99);
    put_byte(8'h99);
    run_random(80);
    drain();

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
